/* rtl/lcm_pkg.sv */
// Shared types and constants for the least common multiple unit.
// Used by lcm_gcd, lcm_div, lcm_mul and lcm_of_two_operands_unit; no dependencies.
package lcm_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int MULT_WIDTH        = 32;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

  typedef struct packed {
    logic go;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } unit_sts_t;

endpackage

/* rtl/lcm_of_two_operands_unit.sv */
// Least common multiple of two unsigned operands: gcd, then first / gcd * second.
// Depends on lcm_pkg, lcm_gcd, lcm_div and lcm_mul.
//
//   channel  | handshake          | words
//   ---------+--------------------+-------------------------------------
//   operands | start, busy        | first_operand, second_operand
//   result   | done (one cycle)   | multiple, zero_operand
//
// A word is taken when start is high and busy is low.
// A zero operand is answered straight from idle; otherwise the binary gcd loop
// runs first, then the serial divider and then the serial multiplier.
// Synchronous reset returns the unit to idle with no result pending.
// The receiver cannot stall: a result is shown for exactly one cycle.
module lcm_of_two_operands_unit #(
  parameter int OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [OPERAND_WIDTH-1:0]         first_operand,
  input  logic [OPERAND_WIDTH-1:0]         second_operand,
  output logic                             done,
  output logic [lcm_pkg::MULT_WIDTH-1:0]   multiple,
  output logic                             zero_operand
);

  lcm_pkg::state_t            state;
  logic [OPERAND_WIDTH-1:0]   a_reg;
  logic [OPERAND_WIDTH-1:0]   b_reg;
  logic [OPERAND_WIDTH-1:0]   g;
  logic [OPERAND_WIDTH-1:0]   q;
  logic [2*OPERAND_WIDTH-1:0] prod;
  logic [2*OPERAND_WIDTH+lcm_pkg::MULT_WIDTH-1:0] prod_ext;
  logic                       accept;
  logic                       has_zero;
  lcm_pkg::unit_ctl_t         gcd_ctl;
  lcm_pkg::unit_ctl_t         div_ctl;
  lcm_pkg::unit_ctl_t         mul_ctl;
  lcm_pkg::unit_sts_t         gcd_sts;
  lcm_pkg::unit_sts_t         div_sts;
  lcm_pkg::unit_sts_t         mul_sts;

  assign busy     = (state != lcm_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign has_zero = (first_operand == '0) || (second_operand == '0);
  assign gcd_ctl  = '{go: accept && !has_zero};
  assign div_ctl  = '{go: gcd_sts.fin};
  assign mul_ctl  = '{go: div_sts.fin};
  assign prod_ext = {{lcm_pkg::MULT_WIDTH{1'b0}}, prod};

  lcm_gcd #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_gcd (
    .clk            (clk),
    .rst            (rst),
    .ctl            (gcd_ctl),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .sts            (gcd_sts),
    .divisor        (g)
  );

  lcm_div #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (a_reg),
    .divisor  (g),
    .sts      (div_sts),
    .quotient (q)
  );

  lcm_mul #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_mul (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mul_ctl),
    .multiplier   (q),
    .multiplicand (b_reg),
    .sts          (mul_sts),
    .product      (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcm_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        lcm_pkg::S_IDLE: begin
          if (start) begin
            a_reg <= first_operand;
            b_reg <= second_operand;
            if (has_zero) begin
              multiple     <= '0;
              zero_operand <= 1'b1;
              done         <= 1'b1;
            end else begin
              state <= lcm_pkg::S_GCD;
            end
          end
        end
        lcm_pkg::S_GCD: begin
          if (gcd_sts.fin) begin
            state <= lcm_pkg::S_DIV;
          end
        end
        lcm_pkg::S_DIV: begin
          if (div_sts.fin) begin
            state <= lcm_pkg::S_MUL;
          end
        end
        lcm_pkg::S_MUL: begin
          if (mul_sts.fin) begin
            multiple     <= prod_ext[lcm_pkg::MULT_WIDTH-1:0];
            zero_operand <= 1'b0;
            done         <= 1'b1;
            state        <= lcm_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lcm_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_one_unit_busy: assert property (@(posedge clk) disable iff (rst)
    $onehot0({gcd_sts.busy, div_sts.busy, mul_sts.busy}))
    else $error("more than one arithmetic unit busy");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(mul_sts.fin) || ($past(accept) && zero_operand))
    else $error("result strobe without a finished product or zero operand");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (done && zero_operand) |-> (multiple == '0))
    else $error("zero operand result is not zero");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted word neither started nor answered");

endmodule

/* rtl/lcm_gcd.sv */
// Binary greatest common divisor, one subtract-or-shift step per cycle.
// Depends on lcm_pkg for the control and status structs.
module lcm_gcd #(
  parameter int OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lcm_pkg::unit_ctl_t       ctl,
  input  logic [OPERAND_WIDTH-1:0] first_operand,
  input  logic [OPERAND_WIDTH-1:0] second_operand,
  output lcm_pkg::unit_sts_t       sts,
  output logic [OPERAND_WIDTH-1:0] divisor
);

  localparam int KW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

  logic [OPERAND_WIDTH-1:0] u;
  logic [OPERAND_WIDTH-1:0] v;
  logic [KW-1:0]            k;
  logic                     busy;
  logic                     unwind;
  logic                     fin;
  logic [OPERAND_WIDTH:0]   diff;

  assign diff    = {1'b0, u} - {1'b0, v};
  assign divisor = u;
  assign sts     = '{busy: busy, fin: fin};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      unwind <= 1'b0;
      fin    <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (ctl.go) begin
        u      <= first_operand;
        v      <= second_operand;
        k      <= '0;
        busy   <= 1'b1;
        unwind <= 1'b0;
      end else if (busy && unwind) begin
        if (k == '0) begin
          busy   <= 1'b0;
          unwind <= 1'b0;
          fin    <= 1'b1;
        end else begin
          u <= {u[OPERAND_WIDTH-2:0], 1'b0};
          k <= k - 1'b1;
        end
      end else if (busy) begin
        if (u == v) begin
          unwind <= 1'b1;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (!diff[OPERAND_WIDTH]) begin
          u <= diff[OPERAND_WIDTH:1];
        end else begin
          v <= (v - u) >> 1;
        end
      end
    end
  end

endmodule

/* rtl/lcm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on lcm_pkg for the control and status structs.
module lcm_div #(
  parameter int OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lcm_pkg::unit_ctl_t       ctl,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output lcm_pkg::unit_sts_t       sts,
  output logic [OPERAND_WIDTH-1:0] quotient
);

  localparam int CW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

  logic [OPERAND_WIDTH-1:0] rem;
  logic [OPERAND_WIDTH-1:0] quo;
  logic [OPERAND_WIDTH-1:0] dsr;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic                     fin;
  logic [OPERAND_WIDTH:0]   part;
  logic [OPERAND_WIDTH:0]   trial;

  assign part     = {rem, quo[OPERAND_WIDTH-1]};
  assign trial    = part - {1'b0, dsr};
  assign quotient = quo;
  assign sts      = '{busy: busy, fin: fin};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (ctl.go) begin
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= CW'(OPERAND_WIDTH - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial[OPERAND_WIDTH]) begin
          rem <= part[OPERAND_WIDTH-1:0];
        end else begin
          rem <= trial[OPERAND_WIDTH-1:0];
        end
        quo <= {quo[OPERAND_WIDTH-2:0], ~trial[OPERAND_WIDTH]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/lcm_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on lcm_pkg for the control and status structs.
module lcm_mul #(
  parameter int OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lcm_pkg::unit_ctl_t         ctl,
  input  logic [OPERAND_WIDTH-1:0]   multiplier,
  input  logic [OPERAND_WIDTH-1:0]   multiplicand,
  output lcm_pkg::unit_sts_t         sts,
  output logic [2*OPERAND_WIDTH-1:0] product
);

  localparam int CW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

  logic [OPERAND_WIDTH-1:0] hi;
  logic [OPERAND_WIDTH-1:0] lo;
  logic [OPERAND_WIDTH-1:0] mcand;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic                     fin;
  logic [OPERAND_WIDTH:0]   sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign product = {hi, lo};
  assign sts     = '{busy: busy, fin: fin};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (ctl.go) begin
        hi    <= '0;
        lo    <= multiplier;
        mcand <= multiplicand;
        cnt   <= CW'(OPERAND_WIDTH - 1);
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= sum[OPERAND_WIDTH:1];
        lo  <= {sum[0], lo[OPERAND_WIDTH-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

endmodule
